// ===== src/tag_frame_crc16_checker_defines.svh =====
// assertion macros for the tag frame crc checker
`ifndef TAG_FRAME_CRC16_CHECKER_DEFINES_SVH
`define TAG_FRAME_CRC16_CHECKER_DEFINES_SVH

// condition must never be seen outside reset
`define TFCC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tfcc_pkg.sv =====
package tfcc_pkg;

  localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CHECK_OFFSET = 2'd0,
    CFG_FRAME_LENGTH = 2'd1
  } tfcc_cfg_index_t;

  localparam logic [7:0] CHECK_OFFSET_RESET = 8'd10;
  localparam logic [7:0] FRAME_LENGTH_RESET = 8'd112;

  // what the back end does with a byte
  typedef enum logic [1:0] {
    KIND_CRC  = 2'd0,
    KIND_HIGH = 2'd1,
    KIND_LOW  = 2'd2
  } tfcc_kind_t;

  typedef struct packed {
    logic [7:0] check_offset;
    logic [7:0] frame_length;
  } tfcc_cfg_t;

  typedef struct packed {
    logic [7:0] data;
    tfcc_kind_t kind;
    logic       restart;
    logic       last;
  } tfcc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tfcc_queue_status_t;

  // one table entry of the reflected crc, eight shift steps on a narrow value
  function automatic logic [15:0] crc_byte_term(input logic [7:0] idx);
    logic [15:0] t;
    t = {8'd0, idx};
    for (int k = 0; k < 8; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ CRC_POLY_REFL;
      end else begin
        t = t >> 1;
      end
    end
    return t;
  endfunction

endpackage

// ===== src/tag_frame_crc16_checker.sv =====
// Tag frame checker with CRC-16/ARC (reflected 0xA001, start 0, no final xor). Frame bytes
// arrive one per transaction with a first_byte mark; every byte except the two-byte check
// field at check_offset (high byte, then low byte) runs through the crc. On the byte at
// position frame_length-1 one result transaction carries the crc and a pass flag. The block
// takes one byte per cycle while byte_stall is low: a front end classifies each byte
// against the configuration and queues it, a back end does the table-form crc update, one
// byte per cycle unless a stalled result holds it, and keeps the result in an output
// register fed from the queue. The queue of QUEUE_DEPTH entries (2 to 16) absorbs output
// stalls before byte_stall rises. No clearing pass after reset. The user writes registers
// through cfg_* only while the block is idle (not enforced); cfg_ready is always high.
module tag_frame_crc16_checker #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] crc_value,
  output logic        check_pass,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import tfcc_pkg::*;

  `include "tag_frame_crc16_checker_defines.svh"

  tfcc_cfg_t          cfg;
  tfcc_entry_t        push_entry;
  tfcc_entry_t        head;
  tfcc_queue_status_t q_status;
  logic               byte_accept;
  logic               pop;
  logic [7:0]         byte_index;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_offset <= CHECK_OFFSET_RESET;
      cfg.frame_length <= FRAME_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CHECK_OFFSET: cfg.check_offset <= cfg_data;
        CFG_FRAME_LENGTH: cfg.frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side stalls only when the queue is full
  assign byte_stall  = q_status.full;
  assign byte_accept = byte_valid && !byte_stall;

  // front end: byte position and classification
  tfcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (byte_accept),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .entry      (push_entry),
    .byte_index (byte_index)
  );

  // short queue between the two halves
  tfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (byte_accept),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // back end: crc update, stored check bytes, result register
  tfcc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .entry        (head),
    .entry_valid  (!q_status.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .crc_value    (crc_value),
    .check_pass   (check_pass)
  );

  // a queue can not be full and empty at once
  `TFCC_ASSERT_NEVER(a_queue_state, q_status.full && q_status.empty, "queue full and empty")

  // a popped last byte always turns into a pending result
  `TFCC_ASSERT_NEXT(a_last_gives_result, pop && head.last, result_valid, "result lost")

  // a first byte of a frame longer than one byte moves the position to one
  `TFCC_ASSERT_NEXT(a_first_restarts, byte_accept && first_byte && (cfg.frame_length != 8'd1),
                    byte_index == 8'd1, "frame restart failed")

endmodule

// ===== src/tfcc_front.sv =====
module tfcc_front (
  input  logic               clk,
  input  logic               rst,
  input  tfcc_pkg::tfcc_cfg_t cfg,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic               first_byte,
  output tfcc_pkg::tfcc_entry_t entry,
  output logic [7:0]         byte_index
);
  import tfcc_pkg::*;

  logic [7:0] pos;
  logic [8:0] lo_pos;
  logic [7:0] last_pos;
  logic       is_last;
  logic [7:0] byte_index_next;

  always_comb begin
    pos      = first_byte ? 8'd0 : byte_index;
    lo_pos   = {1'b0, cfg.check_offset} + 9'd1;
    last_pos = cfg.frame_length - 8'd1;
    is_last  = (pos == last_pos);

    entry.data    = data_byte;
    entry.restart = first_byte;
    entry.last    = is_last;
    if (pos == cfg.check_offset) begin
      entry.kind = KIND_HIGH;
    end else if ({1'b0, pos} == lo_pos) begin
      entry.kind = KIND_LOW;
    end else begin
      entry.kind = KIND_CRC;
    end

    byte_index_next = is_last ? 8'd0 : pos + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= 8'd0;
    end else if (accept) begin
      byte_index <= byte_index_next;
    end
  end

endmodule

// ===== src/tfcc_queue.sv =====
module tfcc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  tfcc_pkg::tfcc_entry_t     push_entry,
  input  logic                      pop,
  output tfcc_pkg::tfcc_entry_t     head,
  output tfcc_pkg::tfcc_queue_status_t status
);
  import tfcc_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tfcc_entry_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (count == CW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== src/tfcc_back.sv =====
module tfcc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  tfcc_pkg::tfcc_entry_t entry,
  input  logic                  entry_valid,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [15:0]           crc_value,
  output logic                  check_pass
);
  import tfcc_pkg::*;

  logic [15:0] crc_acc;
  logic [7:0]  stored_high;
  logic [7:0]  stored_low;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [7:0]  stored_high_next;
  logic [7:0]  stored_low_next;
  logic        pass_next;

  assign pop = entry_valid && (!result_valid || !result_stall);

  always_comb begin
    crc_base         = entry.restart ? 16'd0 : crc_acc;
    stored_high_next = entry.restart ? 8'd0 : stored_high;
    stored_low_next  = entry.restart ? 8'd0 : stored_low;
    crc_next         = crc_base;
    case (entry.kind)
      KIND_HIGH: stored_high_next = entry.data;
      KIND_LOW:  stored_low_next  = entry.data;
      default:   crc_next = {8'd0, crc_base[15:8]} ^ crc_byte_term(crc_base[7:0] ^ entry.data);
    endcase
    pass_next = ({stored_high_next, stored_low_next} == crc_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc     <= 16'd0;
      stored_high <= 8'd0;
      stored_low  <= 8'd0;
    end else if (pop) begin
      if (entry.last) begin
        crc_acc     <= 16'd0;
        stored_high <= 8'd0;
        stored_low  <= 8'd0;
      end else begin
        crc_acc     <= crc_next;
        stored_high <= stored_high_next;
        stored_low  <= stored_low_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && entry.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last) begin
      crc_value  <= crc_next;
      check_pass <= pass_next;
    end
  end

endmodule

// ===== tb/sv/tb_tag_frame_crc16_checker.sv =====
`timescale 1ns / 1ps

module tb_tag_frame_crc16_checker;
  import tfcc_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT      = 300000;
  localparam int DRAIN_CYCLES     = 24;   // block queue plus back end, rounded up
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int MAX_REPORTS      = 10;

  // one byte transaction as the sender offers it
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } frame_byte_t;

  // one frame result as the block should report it
  typedef struct packed {
    logic [15:0] crc;
    logic        pass;
  } crc_result_t;

  // how a generated frame treats its check field
  typedef enum logic [1:0] {
    FR_GOOD, // check field carries the right crc
    FR_BAD,  // good frame with one bit flipped somewhere
    FR_RAW   // bytes as filled, check field left alone
  } frame_kind_t;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } frame_fill_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        result_valid;
  logic        result_stall;
  logic [15:0] crc_value;
  logic        check_pass;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  tag_frame_crc16_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .crc_value    (crc_value),
    .check_pass   (check_pass),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // bytes waiting for the driver, results waiting for the block
  frame_byte_t pending_bytes[$];
  crc_result_t expected_results[$];

  int bytes_queued = 0;
  int bytes_taken = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off, run by its own process
  logic hold_go = 1'b0;
  logic long_hold;

  // register copies as the block should hold them
  tfcc_cfg_t cfg_mirror = '{check_offset: CHECK_OFFSET_RESET,
                            frame_length: FRAME_LENGTH_RESET};

  // frame tracking state of the predictor
  logic [15:0] frame_crc = '0;
  logic [7:0]  frame_pos = '0;
  logic [7:0]  held_high = '0;
  logic [7:0]  held_low = '0;

  // every input known from time zero
  initial begin
    rst          = 1'b1;
    byte_valid   = 1'b0;
    data_byte    = '0;
    first_byte   = 1'b0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_CHECK_OFFSET;
    cfg_data     = '0;
  end

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // bitwise reflected crc-16/arc, one byte in
  function automatic logic [15:0] crc16_arc_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

  // follows the frame as accepted bytes arrive, queues a result on the last byte
  task automatic track_frame_byte(logic [7:0] b, logic first);
    logic [7:0]  last_pos;
    logic [8:0]  low_pos;
    crc_result_t res;
    last_pos = cfg_mirror.frame_length - 8'd1;   // length 0 wraps to a 256-byte frame
    low_pos  = {1'b0, cfg_mirror.check_offset} + 9'd1;
    if (first) begin
      frame_crc = '0;
      frame_pos = '0;
      held_high = '0;
      held_low  = '0;
    end
    // check bytes are kept aside, everything else feeds the crc
    if (frame_pos == cfg_mirror.check_offset) begin
      held_high = b;
    end else if ({1'b0, frame_pos} == low_pos) begin
      held_low = b;
    end else begin
      frame_crc = crc16_arc_step(frame_crc, b);
    end
    if (frame_pos == last_pos) begin
      res.crc  = frame_crc;
      res.pass = ({held_high, held_low} == frame_crc);
      expected_results.push_back(res);
      // frame restarts on its own after the last byte
      frame_crc = '0;
      frame_pos = '0;
      held_high = '0;
      held_low  = '0;
    end else begin
      frame_pos = frame_pos + 8'd1;
    end
  endtask

  task automatic check_result(logic [15:0] crc, logic pass);
    crc_result_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("[%0t] unexpected result: crc %h pass %b", $realtime, crc, pass);
      end
    end else begin
      want = expected_results.pop_front();
      if (crc !== want.crc || pass !== want.pass) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("[%0t] result mismatch: crc %h (want %h) pass %b (want %b)",
                   $realtime, crc, want.crc, pass, want.pass);
        end
      end
    end
  endtask

  // sender: holds a stalled transaction, otherwise takes the next byte or idles
  always @(posedge clk) begin : drive_bytes
    frame_byte_t nxt;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        track_frame_byte(data_byte, first_byte);
        bytes_taken++;
      end
      if (!byte_valid || !byte_stall) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          byte_valid <= 1'b1;
          data_byte  <= nxt.data;
          first_byte <= nxt.first;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result transaction, stalls at random or on the long hold
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(crc_value, check_pass);
      end
      result_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // long hold-off while the sender keeps going, so the block backs up and stalls bytes
  initial begin
    long_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  task automatic queue_byte(logic [7:0] b, logic first);
    frame_byte_t it;
    it.data  = b;
    it.first = first;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  // builds one frame of len bytes against the current check offset
  task automatic push_frame(int len, frame_kind_t kind, logic first, frame_fill_t fill);
    logic [7:0]  frame_buf [256];
    logic [15:0] crc;
    int          hi;
    int          lo;
    int          flip;
    hi = cfg_mirror.check_offset;
    lo = hi + 1;
    for (int k = 0; k < len; k++) begin
      case (fill)
        FILL_ZERO: frame_buf[k] = 8'h00;
        FILL_ONES: frame_buf[k] = 8'hFF;
        default:   frame_buf[k] = 8'($urandom_range(255));
      endcase
    end
    if (kind != FR_RAW) begin
      crc = '0;
      for (int k = 0; k < len; k++) begin
        if (k != hi && k != lo) begin
          crc = crc16_arc_step(crc, frame_buf[k]);
        end
      end
      // check field high byte first; parts past the frame end are simply dropped
      if (hi < len) frame_buf[hi] = crc[15:8];
      if (lo < len) frame_buf[lo] = crc[7:0];
    end
    if (kind == FR_BAD) begin
      flip = $urandom_range(len * 8 - 1);
      frame_buf[flip / 8] = frame_buf[flip / 8] ^ (8'h01 << (flip % 8));
    end
    for (int k = 0; k < len; k++) begin
      queue_byte(frame_buf[k], (k == 0) ? first : 1'b0);
    end
  endtask

  // all bytes taken, all results in, then let the back end run dry
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(tfcc_cfg_index_t idx, logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CHECK_OFFSET: cfg_mirror.check_offset = val;
      CFG_FRAME_LENGTH: cfg_mirror.frame_length = val;
      default: ;
    endcase
  endtask

  task automatic set_frame_format(logic [7:0] offset, logic [7:0] length);
    wait_drained();
    write_reg(CFG_CHECK_OFFSET, offset);
    write_reg(CFG_FRAME_LENGTH, length);
  endtask

  // short frames with random formats: mostly well formed, some corrupted, some noise
  task automatic run_random_frames(int target_items);
    int          items;
    int          len;
    int          nframes;
    int          pick;
    int          noise_len;
    logic [7:0]  offset;
    logic        aligned;
    items = 0;
    while (items < target_items) begin
      len = $urandom_range(16, 3);
      // field inside the frame most of the time, else partly or wholly past the end
      if ($urandom_range(3) != 0) offset = 8'($urandom_range(len - 2));
      else offset = 8'($urandom_range(255, len - 1));
      set_frame_format(offset, 8'(len));
      aligned = 1'b0;
      nframes = $urandom_range(8, 4);
      for (int f = 0; f < nframes; f++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          // an aligned frame may lean on the automatic restart instead of first_byte
          push_frame(len, (pick < 65) ? FR_GOOD : FR_BAD,
                     !aligned || ($urandom_range(3) != 0), FILL_RANDOM);
          aligned = 1'b1;
          items += len;
        end else begin
          noise_len = $urandom_range(6, 1);
          for (int k = 0; k < noise_len; k++) begin
            queue_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
          end
          aligned = 1'b0;
          items += noise_len;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // phase one: sender idles little, receiver a lot
    send_idle_pct = 22;
    recv_idle_pct = 84;

    // reset format: 112-byte tag frame with the field at 10
    push_frame(112, FR_GOOD, 1'b1, FILL_RANDOM);

    // directed: field at the start of a three-byte frame
    set_frame_format(8'd0, 8'd3);
    push_frame(3, FR_GOOD, 1'b1, FILL_ONES);
    push_frame(3, FR_RAW, 1'b1, FILL_ZERO);
    // first_byte restarts a frame part way through
    queue_byte(8'h5A, 1'b1);
    push_frame(3, FR_GOOD, 1'b1, FILL_RANDOM);
    // next frame relies on the restart after the last byte
    push_frame(3, FR_GOOD, 1'b0, FILL_RANDOM);

    // field ending on the last byte
    set_frame_format(8'd1, 8'd3);
    push_frame(3, FR_GOOD, 1'b1, FILL_RANDOM);

    // field never reached, both stored bytes stay zero in the compare
    set_frame_format(8'd2, 8'd2);
    push_frame(2, FR_RAW, 1'b1, FILL_ZERO);

    // one-byte frames, only the high check byte is seen
    set_frame_format(8'd0, 8'd1);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h00, 1'b0);

    // format changed part way through a frame, position keeps counting
    set_frame_format(8'd0, 8'd3);
    queue_byte(8'($urandom_range(255)), 1'b1);
    wait_drained();
    write_reg(CFG_FRAME_LENGTH, 8'd5);
    for (int k = 0; k < 4; k++) begin
      queue_byte(8'($urandom_range(255)), 1'b0);
    end

    run_random_frames(50);

    // phase two: sender idles a lot, receiver little
    wait_drained();
    send_idle_pct = 84;
    recv_idle_pct = 22;
    run_random_frames(50);
    // length 0 means 256 bytes; offset 255 puts the low check byte out of reach
    set_frame_format(8'd255, 8'd0);
    push_frame(256, FR_GOOD, 1'b1, FILL_RANDOM);

    // phase three: no idling, with one long receiver hold-off at the start
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    run_random_frames(50);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
